[hdl/stl_pkg.sv]
// Package for the SPH time-step limiter: widths, constants, register map.
// No dependencies.
`default_nettype none
package stl_pkg;
  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned TimeBits = 48;
  localparam int unsigned CourBits = 17;
  localparam int unsigned AddrBits = 6;
  localparam logic [WordBits-1:0] WordMax = '1;
  localparam logic [12:0] EpsQ032 = 13'd4295;
  localparam logic [13:0] SmoothQ16 = 14'd9830;

  localparam logic [AddrBits-1:0] AddrCourant = 6'd0;
  localparam logic [AddrBits-1:0] AddrStep = 6'd8;
  localparam logic [AddrBits-1:0] AddrTime = 6'd16;
  localparam logic [AddrBits-1:0] AddrEnEnergy = 6'd24;
  localparam logic [AddrBits-1:0] AddrEnSmooth = 6'd32;

  typedef enum logic [2:0] {
    LimSave = 3'd0, LimAccel = 3'd1, LimCfl = 3'd2, LimEnergy = 3'd3, LimSmooth = 3'd4
  } limiter_e;

  typedef struct packed {
    logic signed [WordBits-1:0] accel_x;
    logic signed [WordBits-1:0] accel_y;
    logic signed [WordBits-1:0] accel_z;
    logic [WordBits-1:0] smoothing_length;
    logic [WordBits-1:0] sound_speed;
    logic [WordBits-1:0] specific_energy;
    logic signed [WordBits-1:0] energy_rate;
    logic signed [WordBits-1:0] smoothing_rate;
    logic last_particle;
  } particle_t;

  typedef struct packed {
    logic [WordBits-1:0] step_dt;
    logic [WordBits-1:0] save_dt;
    logic [WordBits-1:0] accel_dt;
    logic [WordBits-1:0] cfl_dt;
    logic [WordBits-1:0] energy_dt;
    logic [WordBits-1:0] smoothing_dt;
    logic [2:0] limiter;
  } result_t;

  // shared unit commands
  typedef enum logic [1:0] {OpSqrt = 2'd0, OpDiv = 2'd1} op_e;
  typedef struct packed {
    logic start;
    op_e op;
  } unit_ctl_t;
endpackage
`default_nettype wire

[hdl/stl_if.sv]
// Valid/ready channel interfaces for particles and results.
// Depends on stl_pkg.
`default_nettype none
interface stl_particle_if import stl_pkg::*; ();
  logic valid;
  logic ready;
  particle_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stl_result_if import stl_pkg::*; ();
  logic valid;
  logic ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/stl_unit.sv]
// Shared iterative unit: 64-bit floor square root or 64/64 floor division
// with remainder, one result bit per cycle. Depends on stl_pkg.
`default_nettype none
module stl_unit import stl_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire unit_ctl_t ctl_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic busy_o,
  output logic [63:0] res_o,
  output logic [63:0] rem_o
);
  logic [63:0] rem_q, rem_d, res_q, res_d, div_q, div_d, num_q, num_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  op_e op_q, op_d;
  logic [64:0] trial;
  logic [63:0] rsh;

  always_comb begin
    rem_d = rem_q; res_d = res_q; div_d = div_q; num_d = num_q;
    cnt_d = cnt_q; busy_d = busy_q; op_d = op_q;
    trial = '0; rsh = '0;
    if (ctl_i.start) begin
      busy_d = 1'b1; op_d = ctl_i.op; res_d = '0; rem_d = '0;
      num_d = a_i; div_d = b_i;
      cnt_d = (ctl_i.op == OpDiv) ? 7'd64 : 7'd32;
    end else if (busy_q) begin
      case (op_q)
        OpDiv: begin
          trial = {rem_q, num_q[63]};
          num_d = num_q << 1;
          if (trial >= {1'b0, div_q}) begin
            rem_d = 64'(trial - {1'b0, div_q});
            res_d = {res_q[62:0], 1'b1};
          end else begin
            rem_d = trial[63:0];
            res_d = {res_q[62:0], 1'b0};
          end
        end
        default: begin
          // digit-by-digit root: bring down two bits
          rsh = {rem_q[61:0], num_q[63:62]};
          num_d = num_q << 2;
          trial = {1'b0, res_q[61:0], 2'b01};
          if ({1'b0, rsh} >= trial) begin
            rem_d = 64'({1'b0, rsh} - trial);
            res_d = {res_q[62:0], 1'b1};
          end else begin
            rem_d = rsh;
            res_d = {res_q[62:0], 1'b0};
          end
        end
      endcase
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; op_q <= OpSqrt;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; op_q <= op_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; res_q <= res_d; div_q <= div_d; num_q <= num_d;
  end
  assign busy_o = busy_q;
  assign res_o = res_q;
  assign rem_o = rem_q;
endmodule
`default_nettype wire

[hdl/sph_timestep_limiter.sv]
// SPH time-step limiter top level: sequencer, minima, config registers.
// Depends on stl_pkg, stl_if, stl_unit.
//
// Usage: particles enter on in_if (valid/ready); a request is taken when the
// block is idle. Each particle runs on one shared root/divide unit, one bit
// per cycle: a 32-step root of |a|^2, a 64-step divide h/|a|, a 32-step root,
// then one to three 64-step divides (h/cs, u/-dudt, h/-dhdt); the first three
// are skipped for zero acceleration. The particle marked last also runs one
// 64-step divide for the dump boundary, then a scaling step and a compare
// step; its result is held in an output register on out_if until taken. The
// next particle is accepted meanwhile; a stalled receiver holds only the
// next last particle in its final step. Reset loads the register defaults
// and sets all minima to all-ones. Config is written over the APB port at
// byte address 8*i, pready always high, reads return values.
`default_nettype none
module sph_timestep_limiter import stl_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stl_particle_if.sink in_if,
  stl_result_if.source out_if,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  typedef enum logic [9:0] {
    SIdle = 10'b0000000001, SMag = 10'b0000000010, SDivA = 10'b0000000100,
    SRoot = 10'b0000001000, SCfl = 10'b0000010000, SEn = 10'b0000100000,
    SSm = 10'b0001000000, SSave = 10'b0010000000, SFin = 10'b0100000000,
    SOut = 10'b1000000000
  } state_e;

  state_e st_q, st_d;
  logic [CourBits-1:0] cour_q;
  logic [TimeBits-1:0] step_q, time_q;
  logic en_e_q, en_s_q;
  logic [WordBits-1:0] ma_q, mc_q, me_q, ms_q, ma_d, mc_d, me_d, ms_d;
  particle_t p_q;
  logic wait_q, wait_d; // unit started last cycle, result pending
  logic [63:0] sum_q, sum_d;
  logic [1:0] sq_q, sq_d;
  result_t r_q, r_d;
  logic ov_q, ov_d;
  unit_ctl_t ctl;
  logic [63:0] ua, ub, ures, urem;
  logic ubusy;
  logic [WordBits-1:0] qsat, ax, ay, az, ecap, scap, sel_v;
  logic [63:0] mulp;
  logic [TimeBits+13:0] epsp;
  logic [TimeBits:0] tdiff;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_comb begin
    case (paddr)
      AddrCourant:  prdata = 64'(cour_q);
      AddrStep:     prdata = 64'(step_q);
      AddrTime:     prdata = 64'(time_q);
      AddrEnEnergy: prdata = 64'(en_e_q);
      AddrEnSmooth: prdata = 64'(en_s_q);
      default:      prdata = '0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cour_q <= CourBits'(19661); step_q <= TimeBits'(65536); time_q <= '0;
      en_e_q <= 1'b0; en_s_q <= 1'b0;
    end else if (wr) begin
      case (paddr)
        AddrCourant:  cour_q <= pwdata[CourBits-1:0];
        AddrStep:     step_q <= pwdata[TimeBits-1:0];
        AddrTime:     time_q <= pwdata[TimeBits-1:0];
        AddrEnEnergy: en_e_q <= pwdata[0];
        AddrEnSmooth: en_s_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  stl_unit u_unit (.clk_i, .rst_ni, .ctl_i(ctl), .a_i(ua), .b_i(ub),
                   .busy_o(ubusy), .res_o(ures), .rem_o(urem));

  assign ax = p_q.accel_x[WordBits-1] ? WordBits'(-p_q.accel_x) : p_q.accel_x;
  assign ay = p_q.accel_y[WordBits-1] ? WordBits'(-p_q.accel_y) : p_q.accel_y;
  assign az = p_q.accel_z[WordBits-1] ? WordBits'(-p_q.accel_z) : p_q.accel_z;
  assign ecap = WordBits'(-p_q.energy_rate);
  assign scap = WordBits'(-p_q.smoothing_rate);
  assign qsat = (ures[63:WordBits] != '0) ? WordMax : ures[WordBits-1:0];

  assign in_if.ready = (st_q == SIdle);

  always_comb begin
    st_d = st_q; wait_d = 1'b0; ctl = '{start: 1'b0, op: OpSqrt};
    ua = '0; ub = '0; sum_d = sum_q; sq_d = sq_q;
    ma_d = ma_q; mc_d = mc_q; me_d = me_q; ms_d = ms_q;
    r_d = r_q; ov_d = ov_q && !out_if.ready;
    mulp = '0; epsp = '0; tdiff = '0; sel_v = '0;
    case (st_q)
      SIdle: begin
        if (in_if.valid) begin
          st_d = SMag; sum_d = '0; sq_d = 2'd0;
        end
      end
      SMag: begin
        // one square per cycle, then start the root, or go to the CFL step if the sum is zero
        case (sq_q)
          2'd0: mulp = 64'(ax) * 64'(ax);
          2'd1: mulp = 64'(ay) * 64'(ay);
          default: mulp = 64'(az) * 64'(az);
        endcase
        if (sq_q != 2'd3) begin
          sum_d = sum_q + mulp; sq_d = sq_q + 2'd1;
        end else if (sum_q == '0) begin
          st_d = SCfl;
        end else begin
          ctl = '{start: 1'b1, op: OpSqrt}; ua = sum_q; wait_d = 1'b1; st_d = SDivA;
        end
      end
      SDivA: begin
        if (!wait_q && !ubusy) begin
          ctl = '{start: 1'b1, op: OpDiv}; wait_d = 1'b1;
          ua = {16'(0), p_q.smoothing_length, 16'(0)}; ub = ures; st_d = SRoot;
        end
      end
      SRoot: begin
        if (!wait_q && !ubusy) begin
          ctl = '{start: 1'b1, op: OpSqrt}; wait_d = 1'b1;
          ua = {16'(0), qsat, 16'(0)}; st_d = SCfl;
          sum_d = 64'(1);
        end
      end
      SCfl: begin
        if (!wait_q && !ubusy) begin
          if (sum_q != '0 && qsat < ma_q) ma_d = qsat;
          ctl = '{start: 1'b1, op: OpDiv}; wait_d = 1'b1;
          ua = {16'(0), p_q.smoothing_length, 16'(0)}; ub = 64'(p_q.sound_speed);
          st_d = SEn;
        end
      end
      SEn: begin
        if (!wait_q && !ubusy) begin
          if (p_q.sound_speed == '0) sel_v = WordMax; else sel_v = qsat;
          if (sel_v < mc_q) mc_d = sel_v;
          st_d = SSm;
          if (en_e_q && p_q.energy_rate[WordBits-1]) begin
            ctl = '{start: 1'b1, op: OpDiv}; wait_d = 1'b1;
            ua = {16'(0), p_q.specific_energy, 16'(0)}; ub = 64'(ecap);
          end
        end
      end
      SSm: begin
        if (!wait_q && !ubusy) begin
          if (en_e_q && p_q.energy_rate[WordBits-1] && qsat < me_q) me_d = qsat;
          st_d = SSave;
          if (en_s_q && p_q.smoothing_rate[WordBits-1]) begin
            ctl = '{start: 1'b1, op: OpDiv}; wait_d = 1'b1;
            ua = {16'(0), p_q.smoothing_length, 16'(0)}; ub = 64'(scap);
          end
        end
      end
      SSave: begin
        if (!wait_q && !ubusy) begin
          if (en_s_q && p_q.smoothing_rate[WordBits-1] && qsat < ms_q) ms_d = qsat;
          if (!p_q.last_particle) st_d = SIdle;
          else begin
            epsp = 62'(step_q) * 62'(EpsQ032);
            ctl = '{start: 1'b1, op: OpDiv}; wait_d = 1'b1;
            ua = 64'(time_q) + 64'(epsp[TimeBits+13:32]);
            ub = {16'(0), step_q}; st_d = SFin;
          end
        end
      end
      SFin: begin
        if (!wait_q && !ubusy && !ov_q) begin
          r_d.save_dt = WordMax;
          if (step_q != '0) begin
            // (k+1)*step - time = step - rem + eps
            epsp = 62'(step_q) * 62'(EpsQ032);
            tdiff = {1'b0, step_q} - {1'b0, urem[TimeBits-1:0]}
                  + 49'(epsp[TimeBits+13:32]);
            r_d.save_dt = (tdiff[TimeBits:WordBits] != '0) ? WordMax
                        : tdiff[WordBits-1:0];
          end
          r_d.accel_dt = (ma_q == WordMax) ? WordMax : (ma_q >> 1);
          mulp = 64'(mc_q) * 64'(cour_q);
          r_d.cfl_dt = (mc_q == WordMax) ? WordMax :
            ((mulp[63:48] != '0) ? WordMax : mulp[47:16]);
          r_d.energy_dt = me_q;
          epsp = 62'(ms_q) * 62'(SmoothQ16);
          r_d.smoothing_dt = (ms_q == WordMax) ? WordMax : epsp[47:16];
          st_d = SOut;
        end
      end
      SOut: begin
        r_d.step_dt = r_q.save_dt; r_d.limiter = LimSave;
        if (r_q.accel_dt < r_d.step_dt) begin
          r_d.step_dt = r_q.accel_dt; r_d.limiter = LimAccel;
        end
        if (r_q.cfl_dt < r_d.step_dt) begin
          r_d.step_dt = r_q.cfl_dt; r_d.limiter = LimCfl;
        end
        if (r_q.energy_dt < r_d.step_dt) begin
          r_d.step_dt = r_q.energy_dt; r_d.limiter = LimEnergy;
        end
        if (r_q.smoothing_dt < r_d.step_dt) begin
          r_d.step_dt = r_q.smoothing_dt; r_d.limiter = LimSmooth;
        end
        ov_d = 1'b1;
        ma_d = WordMax; mc_d = WordMax; me_d = WordMax; ms_d = WordMax;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; wait_q <= 1'b0; ov_q <= 1'b0;
      ma_q <= WordMax; mc_q <= WordMax; me_q <= WordMax; ms_q <= WordMax;
    end else begin
      st_q <= st_d; wait_q <= wait_d; ov_q <= ov_d;
      ma_q <= ma_d; mc_q <= mc_d; me_q <= me_d; ms_q <= ms_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) p_q <= in_if.data;
    sum_q <= sum_d; sq_q <= sq_d; r_q <= r_d;
  end

  assign out_if.valid = ov_q;
  assign out_if.data = r_q;
endmodule
`default_nettype wire

[hdl/stl_checker.sv]
// Port-level checks for the time-step limiter, bound to the top level.
// Depends on stl_pkg.
`default_nettype none
module stl_checker import stl_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire result_t out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.limiter <= 3'd4) else $error("bad limiter");
  a_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.step_dt <= out_data.save_dt) else $error("step above save");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("ready after request");
endmodule

bind sph_timestep_limiter stl_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data));
`default_nettype wire
